// File: hw/rtl/cart_pendulum_derivative_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pendulum derivative core
// Shared concurrent-check shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CART_PENDULUM_DERIVATIVE_CORE_DEFINES_SVH
`define CART_PENDULUM_DERIVATIVE_CORE_DEFINES_SVH

// same-cycle implication
`define CPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpd: same-cycle check failed");

// next-cycle implication
`define CPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpd: next-cycle check failed");

`endif

// File: hw/rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, constants and helpers of the pendulum derivative core.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QF            = 30;
    localparam int HCELLS        = 7;
    localparam int SIN_TERMS     = 6;
    localparam int QB            = 33;
    localparam int DW            = 30;

    localparam logic signed [32:0] ONE33 = 33'sd1 <<< QF;

    typedef struct packed {
        logic signed [18:0] angle;
        logic signed [23:0] angular_velocity;
        logic signed [23:0] force_req;
    } t_in_beat;

    typedef struct packed {
        logic signed [23:0] angle_rate;
        logic signed [31:0] angular_accel;
    } t_out_beat;

    // Horner cell carry
    typedef struct packed {
        logic [31:0]        x2;
        logic signed [32:0] ts;
        logic signed [32:0] tc;
        logic signed [31:0] r;
        logic               flip;
        logic signed [23:0] w;
        logic signed [23:0] u;
    } t_hcarry;

    // divider cell carry
    typedef struct packed {
        logic [DW-1:0]      rem;
        logic [DW-1:0]      den;
        logic [QB-1:0]      nlow;
        logic [QB-1:0]      q;
        logic               neg;
        logic               big;
        logic signed [23:0] w;
    } t_dcarry;

    function automatic int sin_div(input int idx);
        int d;
        begin
            case (idx)
                0:       d = 156;
                1:       d = 110;
                2:       d = 72;
                3:       d = 42;
                4:       d = 20;
                5:       d = 6;
                default: d = 2;
            endcase
            return d;
        end
    endfunction

    function automatic int cos_div(input int idx);
        int d;
        begin
            case (idx)
                0:       d = 182;
                1:       d = 132;
                2:       d = 90;
                3:       d = 56;
                4:       d = 30;
                5:       d = 12;
                default: d = 2;
            endcase
            return d;
        end
    endfunction

    // arithmetic right shift, round to nearest, ties away from zero
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v, input int sh);
        logic signed [71:0] h;
        begin
            h = 72'sd1 <<< (sh - 1);
            return (v + (v[71] ? (h - 72'sd1) : h)) >>> sh;
        end
    endfunction

endpackage

// File: hw/rtl/cpd_stream_if.sv
// ----------------------------------------------------------------------------
// cpd_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface cpd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/cpd_horner_cell.sv
// ----------------------------------------------------------------------------
// cpd_horner_cell
// One Horner step of the cosine series (and of the sine series below SIN_TERMS), four pipeline stages.
// ----------------------------------------------------------------------------
module cpd_horner_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  cpd_pkg::t_hcarry i_c,
    output logic             o_vld,
    output cpd_pkg::t_hcarry o_c
);
    import cpd_pkg::*;

    localparam bit          SIN_ON = (IDX < SIN_TERMS);
    localparam int          DS     = sin_div(IDX);
    localparam int          DC     = cos_div(IDX);
    localparam logic [31:0] RS     = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] RC     = 32'((64'd1 << 32) / DC);

    logic [3:0] r_v;
    t_hcarry    r_c1, r_c2, r_c3, r_c4;
    t_hcarry    n_c4;

    logic signed [65:0] n_ps, n_pc;
    logic signed [65:0] r_ps1, r_pc1;
    logic signed [33:0] mqs, mqc;
    logic [31:0]        r_ms2, r_mc2, r_ms3, r_mc3;
    logic               r_ns2, r_nc2, r_ns3, r_nc3;
    logic [63:0]        n_es, n_ec;
    logic [31:0]        r_qs3, r_qc3;
    logic [32:0]        qds, qdc, rems, remc;
    logic [31:0]        qs, qc;
    logic signed [32:0] ts_new, tc_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    assign n_ps = $signed({1'b0, i_c.x2}) * i_c.ts;
    assign n_pc = $signed({1'b0, i_c.x2}) * i_c.tc;

    assign mqs = 34'(rnd_shr(72'(r_ps1), QF));
    assign mqc = 34'(rnd_shr(72'(r_pc1), QF));

    assign n_es = r_ms2 * RS;
    assign n_ec = r_mc2 * RC;

    assign qds  = 33'(r_qs3) * 33'(DS);
    assign qdc  = 33'(r_qc3) * 33'(DC);
    assign rems = {1'b0, r_ms3} - qds;
    assign remc = {1'b0, r_mc3} - qdc;
    assign qs   = r_qs3 + 32'(rems >= 33'(DS));
    assign qc   = r_qc3 + 32'(remc >= 33'(DC));
    assign ts_new = r_ns3 ? (ONE33 + $signed({1'b0, qs})) : (ONE33 - $signed({1'b0, qs}));
    assign tc_new = r_nc3 ? (ONE33 + $signed({1'b0, qc})) : (ONE33 - $signed({1'b0, qc}));

    always_comb begin
        n_c4    = r_c3;
        n_c4.ts = SIN_ON ? ts_new : r_c3.ts;
        n_c4.tc = tc_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1  <= i_c;
            r_ps1 <= n_ps;
            r_pc1 <= n_pc;

            r_c2  <= r_c1;
            r_ns2 <= mqs[33];
            r_nc2 <= mqc[33];
            r_ms2 <= mqs[33] ? 32'(-mqs) : 32'(mqs);
            r_mc2 <= mqc[33] ? 32'(-mqc) : 32'(mqc);

            r_c3  <= r_c2;
            r_ms3 <= r_ms2;
            r_mc3 <= r_mc2;
            r_ns3 <= r_ns2;
            r_nc3 <= r_nc2;
            r_qs3 <= n_es[63:32];
            r_qc3 <= n_ec[63:32];

            r_c4  <= n_c4;
        end
    end

    assign o_vld = r_v[3];
    assign o_c   = r_c4;
endmodule

// File: hw/rtl/cpd_div_cell.sv
// ----------------------------------------------------------------------------
// cpd_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module cpd_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  cpd_pkg::t_dcarry i_c,
    output logic             o_vld,
    output cpd_pkg::t_dcarry o_c
);
    import cpd_pkg::*;

    logic          r_vld;
    t_dcarry       r_c;
    t_dcarry       n_c;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {i_c.rem, i_c.nlow[QB-1]};
    assign ge    = trial >= {1'b0, i_c.den};
    assign diff  = trial - {1'b0, i_c.den};

    always_comb begin
        n_c      = i_c;
        n_c.rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_c.nlow = {i_c.nlow[QB-2:0], 1'b0};
        n_c.q    = {i_c.q[QB-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_vld = r_vld;
    assign o_c   = r_c;
endmodule

// File: hw/rtl/cart_pendulum_derivative_core.sv
// ----------------------------------------------------------------------------
// cart_pendulum_derivative_core
// Pendulum-on-cart derivative: angle rate and saturated angular acceleration.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every cycle while the output is not held,
// and each result passes through five angle stages, seven four-stage Horner
// cells for sine and cosine, thirteen numerator/denominator stages, a chain of
// 33 one-bit division cells and the output register. The whole pipeline holds
// while a finished result waits on the output.
// ----------------------------------------------------------------------------
`include "cart_pendulum_derivative_core_defines.svh"

module cart_pendulum_derivative_core #(
    parameter int FRAC_BITS = cpd_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cpd_stream_if.sink      i_in,
    cpd_stream_if.source    o_out
);
    import cpd_pkg::*;

    localparam int SH   = QF - FRAC_BITS;
    localparam int A30W = 19 + SH;
    localparam int CW   = (A30W > 34) ? A30W : 34;
    localparam int T2SH = 2 * FRAC_BITS - 10;
    localparam int NW   = 64 + FRAC_BITS;
    localparam int HW   = NW - QB;

    localparam logic signed [33:0] PI_Q30   = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI  = 34'sd1686629713;
    localparam logic signed [27:0] A_Q30    = 28'sd107374182;
    localparam logic signed [27:0] AML_Q30  = 28'sd107374182;
    localparam logic signed [31:0] MOI_Q30  = 32'sd715827882;
    localparam logic [31:0]        R5       = 32'd858993459;
    localparam logic [32:0]        FIVE     = 33'd5;
    localparam logic [32:0]        MAG_NEG  = 33'd2147483648;
    localparam logic [32:0]        MAG_POS  = 33'd2147483647;
    localparam logic signed [31:0] ACC_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] ACC_MAX  = 32'sh7fff_ffff;

    function automatic logic [5:0] t1_frac(input logic [2:0] b);
        logic [5:0] f;
        begin
            unique case (b)
                3'd1:    f = 6'd9;
                3'd2:    f = 6'd19;
                3'd3:    f = 6'd29;
                3'd4:    f = 6'd39;
                default: f = 6'd0;
            endcase
            return f;
        end
    endfunction

    logic en;
    logic [4:0]  r_pv;
    logic [12:0] r_qv;
    logic        r_out_vld;
    t_out_beat   r_out;

    assign en          = !r_out_vld || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_out_vld;
    assign o_out.payload = r_out;

    // ---------------- angle front end
    t_in_beat           r_p0;
    logic signed [33:0] r_p1_a;
    logic signed [23:0] r_p1_w, r_p1_u;
    logic signed [31:0] r_p2_r;
    logic               r_p2_flip;
    logic signed [23:0] r_p2_w, r_p2_u;
    logic signed [63:0] r_p3_sq;
    logic signed [31:0] r_p3_r;
    logic               r_p3_flip;
    logic signed [23:0] r_p3_w, r_p3_u;
    t_hcarry            r_p4;

    logic signed [CW-1:0] a30;
    logic signed [CW-1:0] a30c;
    logic signed [63:0]   n_sq;

    assign a30  = CW'(r_p0.angle) <<< SH;
    assign a30c = (a30 > CW'(PI_Q30)) ? CW'(PI_Q30) :
                  (a30 < -CW'(PI_Q30)) ? -CW'(PI_Q30) : a30;
    assign n_sq = r_p2_r * r_p2_r;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0   <= i_in.payload;

            r_p1_a <= 34'(a30c);
            r_p1_w <= r_p0.angular_velocity;
            r_p1_u <= r_p0.force_req;

            if (r_p1_a > HALF_PI) begin
                r_p2_r    <= 32'(PI_Q30 - r_p1_a);
                r_p2_flip <= 1'b1;
            end else if (r_p1_a < -HALF_PI) begin
                r_p2_r    <= 32'(-PI_Q30 - r_p1_a);
                r_p2_flip <= 1'b1;
            end else begin
                r_p2_r    <= 32'(r_p1_a);
                r_p2_flip <= 1'b0;
            end
            r_p2_w <= r_p1_w;
            r_p2_u <= r_p1_u;

            r_p3_sq   <= n_sq;
            r_p3_r    <= r_p2_r;
            r_p3_flip <= r_p2_flip;
            r_p3_w    <= r_p2_w;
            r_p3_u    <= r_p2_u;

            r_p4.x2   <= 32'(rnd_shr(72'(r_p3_sq), QF));
            r_p4.ts   <= ONE33;
            r_p4.tc   <= ONE33;
            r_p4.r    <= r_p3_r;
            r_p4.flip <= r_p3_flip;
            r_p4.w    <= r_p3_w;
            r_p4.u    <= r_p3_u;
        end
    end

    // ---------------- Horner cell row
    t_hcarry h_c   [HCELLS+1];
    logic    h_vld [HCELLS+1];

    assign h_c[0]   = r_p4;
    assign h_vld[0] = r_pv[4];

    for (genvar gi = 0; gi < HCELLS; gi++) begin : g_hc
        cpd_horner_cell #(
            .IDX(gi)
        ) u_hc (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (h_vld[gi]),
            .i_c    (h_c[gi]),
            .o_vld  (h_vld[gi+1]),
            .o_c    (h_c[gi+1])
        );
    end

    // ---------------- numerator / denominator
    t_hcarry ho;
    assign ho = h_c[HCELLS];

    logic signed [64:0] r_q1_sp, n_sp;
    logic signed [65:0] r_q1_ccp, n_ccp;
    logic signed [32:0] r_q1_c;
    logic signed [23:0] r_q1_w, r_q1_u;

    logic signed [32:0] r_q2_s, r_q2_cc, r_q2_c;
    logic [46:0]        r_q2_w2;
    logic signed [47:0] n_w2;
    logic signed [23:0] r_q2_w, r_q2_u;

    logic signed [65:0] r_q3_scp, n_scp;
    logic signed [60:0] r_q3_acp, n_acp, r_q3_dcp, n_dcp;
    logic [31:0]        r_q3_as, n_as;
    logic               r_q3_sneg;
    logic [31:0]        r_q3_a5e;
    logic [63:0]        n_s5p;
    logic [46:0]        r_q3_w2;
    logic signed [23:0] r_q3_w, r_q3_u;

    logic signed [32:0] r_q4_sc;
    logic signed [28:0] r_q4_ac, r_q4_dc;
    logic [31:0]        r_q4_a5;
    logic [2:0]         r_q4_b;
    logic               r_q4_sneg;
    logic [46:0]        r_q4_w2;
    logic signed [23:0] r_q4_w, r_q4_u;
    logic [32:0]        q4_p5, q4_rem;
    logic               q4_ge;

    logic signed [60:0] r_q5_kp, n_kp;
    logic signed [52:0] r_q5_t3p, n_t3p;
    logic [DW-1:0]      r_q5_den;
    logic signed [36:0] r_q5_t1;
    logic [46:0]        r_q5_w2;
    logic signed [23:0] r_q5_w;
    logic signed [31:0] q5_dn;
    logic [35:0]        q5_t1m;

    logic signed [32:0] r_q6_k20a;
    logic signed [47:0] r_q6_t3;
    logic [DW-1:0]      r_q6_den;
    logic signed [36:0] r_q6_t1;
    logic [46:0]        r_q6_w2;
    logic signed [23:0] r_q6_w;

    logic signed [23:0] r_q7_k20;
    logic signed [47:0] r_q7_t3;
    logic [DW-1:0]      r_q7_den;
    logic signed [36:0] r_q7_t1;
    logic [46:0]        r_q7_w2;
    logic signed [23:0] r_q7_w;

    logic signed [48:0] r_q8_lo, n_lo;
    logic signed [47:0] r_q8_hi, n_hi;
    logic signed [47:0] r_q8_t3;
    logic [DW-1:0]      r_q8_den;
    logic signed [36:0] r_q8_t1;
    logic signed [23:0] r_q8_w;

    logic signed [71:0] r_q9_t2p;
    logic signed [47:0] r_q9_t3;
    logic [DW-1:0]      r_q9_den;
    logic signed [36:0] r_q9_t1;
    logic signed [23:0] r_q9_w;

    logic signed [63:0] r_q10_t2;
    logic signed [47:0] r_q10_t3;
    logic [DW-1:0]      r_q10_den;
    logic signed [36:0] r_q10_t1;
    logic signed [23:0] r_q10_w;

    logic signed [63:0] r_q11_num;
    logic [DW-1:0]      r_q11_den;
    logic signed [23:0] r_q11_w;

    logic [63:0]        r_q12_un;
    logic               r_q12_neg;
    logic [DW-1:0]      r_q12_den;
    logic signed [23:0] r_q12_w;

    logic [NW-1:0]      q12_n;
    logic [HW-1:0]      q12_hi;
    t_dcarry            r_q13;

    assign n_sp  = ho.r * ho.ts;
    assign n_ccp = ho.tc * ho.tc;
    assign n_w2  = r_q1_w * r_q1_w;
    assign n_scp = r_q2_s * r_q2_c;
    assign n_acp = A_Q30 * r_q2_c;
    assign n_dcp = AML_Q30 * r_q2_cc;
    assign n_as  = r_q2_s[32] ? 32'(-r_q2_s) : 32'(r_q2_s);
    assign n_s5p = n_as * R5;
    assign q4_p5  = 33'(r_q3_a5e) * FIVE;
    assign q4_rem = {1'b0, r_q3_as} - q4_p5;
    assign q4_ge  = q4_rem >= FIVE;
    assign n_kp  = AML_Q30 * r_q4_sc;
    assign n_t3p = r_q4_ac * r_q4_u;
    assign q5_dn = MOI_Q30 - 32'(r_q4_dc);
    assign q5_t1m = 36'(r_q4_a5) * 36'd49 + 36'(t1_frac(r_q4_b));
    assign n_lo  = r_q7_k20 * $signed({1'b0, r_q7_w2[23:0]});
    assign n_hi  = r_q7_k20 * $signed({1'b0, r_q7_w2[46:24]});
    assign q12_n  = {r_q12_un, {FRAC_BITS{1'b0}}};
    assign q12_hi = q12_n[NW-1:QB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_sp  <= n_sp;
            r_q1_ccp <= n_ccp;
            r_q1_c   <= ho.flip ? -ho.tc : ho.tc;
            r_q1_w   <= ho.w;
            r_q1_u   <= ho.u;

            r_q2_s   <= 33'(rnd_shr(72'(r_q1_sp), QF));
            r_q2_cc  <= 33'(rnd_shr(72'(r_q1_ccp), QF));
            r_q2_c   <= r_q1_c;
            r_q2_w2  <= n_w2[46:0];
            r_q2_w   <= r_q1_w;
            r_q2_u   <= r_q1_u;

            r_q3_scp  <= n_scp;
            r_q3_acp  <= n_acp;
            r_q3_dcp  <= n_dcp;
            r_q3_as   <= n_as;
            r_q3_sneg <= r_q2_s[32];
            r_q3_a5e  <= n_s5p[63:32];
            r_q3_w2   <= r_q2_w2;
            r_q3_w    <= r_q2_w;
            r_q3_u    <= r_q2_u;

            r_q4_sc   <= 33'(rnd_shr(72'(r_q3_scp), QF));
            r_q4_ac   <= 29'(rnd_shr(72'(r_q3_acp), QF));
            r_q4_dc   <= 29'(rnd_shr(72'(r_q3_dcp), QF));
            r_q4_a5   <= r_q3_a5e + 32'(q4_ge);
            r_q4_b    <= q4_ge ? 3'(q4_rem - FIVE) : 3'(q4_rem);
            r_q4_sneg <= r_q3_sneg;
            r_q4_w2   <= r_q3_w2;
            r_q4_w    <= r_q3_w;
            r_q4_u    <= r_q3_u;

            r_q5_kp  <= n_kp;
            r_q5_t3p <= n_t3p;
            r_q5_den <= (q5_dn < 32'sd1) ? DW'(1) : q5_dn[DW-1:0];
            r_q5_t1  <= r_q4_sneg ? -$signed({1'b0, q5_t1m}) : $signed({1'b0, q5_t1m});
            r_q5_w2  <= r_q4_w2;
            r_q5_w   <= r_q4_w;

            r_q6_k20a <= 33'(rnd_shr(72'(r_q5_kp), QF));
            r_q6_t3   <= 48'(rnd_shr(72'(r_q5_t3p), FRAC_BITS));
            r_q6_den  <= r_q5_den;
            r_q6_t1   <= r_q5_t1;
            r_q6_w2   <= r_q5_w2;
            r_q6_w    <= r_q5_w;

            r_q7_k20 <= 24'(rnd_shr(72'(r_q6_k20a), QF - 20));
            r_q7_t3  <= r_q6_t3;
            r_q7_den <= r_q6_den;
            r_q7_t1  <= r_q6_t1;
            r_q7_w2  <= r_q6_w2;
            r_q7_w   <= r_q6_w;

            r_q8_lo  <= n_lo;
            r_q8_hi  <= n_hi;
            r_q8_t3  <= r_q7_t3;
            r_q8_den <= r_q7_den;
            r_q8_t1  <= r_q7_t1;
            r_q8_w   <= r_q7_w;

            r_q9_t2p <= 72'(r_q8_lo) + (72'(r_q8_hi) <<< 24);
            r_q9_t3  <= r_q8_t3;
            r_q9_den <= r_q8_den;
            r_q9_t1  <= r_q8_t1;
            r_q9_w   <= r_q8_w;

            r_q10_t2  <= 64'(rnd_shr(r_q9_t2p, T2SH));
            r_q10_t3  <= r_q9_t3;
            r_q10_den <= r_q9_den;
            r_q10_t1  <= r_q9_t1;
            r_q10_w   <= r_q9_w;

            r_q11_num <= 64'(r_q10_t1) - r_q10_t2 - 64'(r_q10_t3);
            r_q11_den <= r_q10_den;
            r_q11_w   <= r_q10_w;

            r_q12_un  <= r_q11_num[63] ? 64'(-r_q11_num) : 64'(r_q11_num);
            r_q12_neg <= r_q11_num[63];
            r_q12_den <= r_q11_den;
            r_q12_w   <= r_q11_w;

            r_q13.rem  <= q12_hi[DW-1:0];
            r_q13.den  <= r_q12_den;
            r_q13.nlow <= q12_n[QB-1:0];
            r_q13.q    <= '0;
            r_q13.neg  <= r_q12_neg;
            r_q13.big  <= q12_hi >= HW'(r_q12_den);
            r_q13.w    <= r_q12_w;
        end
    end

    // ---------------- divider cell row
    t_dcarry d_c   [QB+1];
    logic    d_vld [QB+1];

    assign d_c[0]   = r_q13;
    assign d_vld[0] = r_qv[12];

    for (genvar gd = 0; gd < QB; gd++) begin : g_dc
        cpd_div_cell u_dc (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (d_vld[gd]),
            .i_c    (d_c[gd]),
            .o_vld  (d_vld[gd+1]),
            .o_c    (d_c[gd+1])
        );
    end

    // ---------------- saturation and output beat
    t_dcarry            dq;
    logic signed [31:0] n_acc;

    assign dq = d_c[QB];

    always_comb begin
        if (dq.big) begin
            n_acc = dq.neg ? ACC_MIN : ACC_MAX;
        end else if (dq.neg) begin
            n_acc = (dq.q > MAG_NEG) ? ACC_MIN : 32'(-$signed({1'b0, dq.q}));
        end else begin
            n_acc = (dq.q > MAG_POS) ? ACC_MAX : $signed(dq.q[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_qv      <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_pv      <= {r_pv[3:0], i_in.valid};
            r_qv      <= {r_qv[11:0], h_vld[HCELLS]};
            r_out_vld <= d_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.angle_rate    <= dq.w;
            r_out.angular_accel <= n_acc;
        end
    end

    `CPD_ASSERT_IMPL(a_hold_blocks_input, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    `CPD_ASSERT_IMPL(a_div_rem_below_den, i_clk, i_rst_n, d_vld[QB], dq.rem < dq.den)
endmodule
